FILE: design/sorted_fault_record_set_macros.svh
`ifndef SORTED_FAULT_RECORD_SET_MACROS_SVH
`define SORTED_FAULT_RECORD_SET_MACROS_SVH

// same-cycle implication, held off during reset
`define SFRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SFRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset
`define SFRS_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/sfrs_pkg.sv
package sfrs_pkg;

  localparam int DEPTH_DEF    = 8;
  localparam int ID_WIDTH_DEF = 8;

  localparam int FIELD_ID_W = 8;
  localparam int KIND_W     = 5;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int REC_CNT_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INSTR_WC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_WC  = 1'd1;

  localparam logic [KIND_W-1:0] FaultMMUTranslation  = 5'd7;
  localparam logic [KIND_W-1:0] FaultMMUAccessFlag   = 5'd8;
  localparam logic [KIND_W-1:0] FaultMMUPermission   = 5'd9;
  localparam logic [KIND_W-1:0] FaultDMMUTranslation = 5'd10;
  localparam logic [KIND_W-1:0] FaultDMMUAccessFlag  = 5'd11;
  localparam logic [KIND_W-1:0] FaultDMMUPermission  = 5'd12;
  localparam logic [KIND_W-1:0] FaultIMMUTranslation = 5'd14;
  localparam logic [KIND_W-1:0] FaultIMMUAccessFlag  = 5'd15;
  localparam logic [KIND_W-1:0] FaultIMMUPermission  = 5'd16;
  localparam logic [KIND_W-1:0] FaultUnknown         = 5'd20;

  typedef struct packed {
    logic ins;
    logic clr;
  } sfrs_ctrl_t;

  typedef struct packed {
    logic valid;
    logic shift;
    logic dup;
    logic hit;
  } sfrs_stat_t;

  function automatic logic kind_match(input logic [KIND_W-1:0] q, input logic [KIND_W-1:0] k);
    logic m;
    case (q)
      FaultUnknown:        m = 1'b1;
      FaultMMUTranslation: m = (k == q) || (k == FaultDMMUTranslation) ||
                               (k == FaultIMMUTranslation);
      FaultMMUPermission:  m = (k == q) || (k == FaultDMMUPermission) ||
                               (k == FaultIMMUPermission);
      FaultMMUAccessFlag:  m = (k == q) || (k == FaultDMMUAccessFlag) ||
                               (k == FaultIMMUAccessFlag);
      default:             m = (k == q);
    endcase
    return m;
  endfunction

endpackage

FILE: design/sfrs_cell.sv
module sfrs_cell import sfrs_pkg::*; #(
  parameter int ID_WIDTH = ID_WIDTH_DEF,
  localparam int KEY_W = 2 * ID_WIDTH + KIND_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sfrs_ctrl_t          ctrl,
  input  logic [KEY_W-1:0]    new_key,
  input  logic [ID_WIDTH-1:0] instr_wc,
  input  logic [ID_WIDTH-1:0] data_wc,
  input  logic [KEY_W-1:0]    prev_key,
  input  logic                prev_valid,
  input  logic                prev_shift,
  output logic [KEY_W-1:0]    key,
  output sfrs_stat_t          stat
);

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic             valid_r;
  logic             valid_nxt;

  logic [ID_WIDTH-1:0] q_instr, q_data, r_instr, r_data;
  logic [KIND_W-1:0]   q_kind, r_kind;
  logic                shift, match;

  assign q_instr = new_key[KEY_W-1 -: ID_WIDTH];
  assign q_data  = new_key[KIND_W +: ID_WIDTH];
  assign q_kind  = new_key[KIND_W-1:0];
  assign r_instr = key_r[KEY_W-1 -: ID_WIDTH];
  assign r_data  = key_r[KIND_W +: ID_WIDTH];
  assign r_kind  = key_r[KIND_W-1:0];

  assign shift = !valid_r || (new_key < key_r);
  assign match = ((q_instr == instr_wc) || (q_instr == r_instr)) &&
                 ((q_data == data_wc) || (q_data == r_data)) &&
                 kind_match(q_kind, r_kind);

  assign stat.valid = valid_r;
  assign stat.shift = shift;
  assign stat.dup   = valid_r && (new_key == key_r);
  assign stat.hit   = valid_r && match;
  assign key        = key_r;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.ins && shift) begin
      key_nxt   = prev_shift ? prev_key : new_key;
      valid_nxt = valid_r || prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

FILE: design/sorted_fault_record_set.sv
// The result word is registered and appears in the cycle after its input word
// is accepted. Throughput: one word per cycle while results drain; each cell
// of the chain compares against the incoming record and shifts toward its
// neighbor in the same cycle. Input is taken whenever the result register is
// empty or being drained. Reset (synchronous, active low) empties the set and
// the result register and sets both wildcard codes to zero.
module sorted_fault_record_set import sfrs_pkg::*; #(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] instr_id, [15:8] data_id, [20:16] fault_kind, [23:21] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] insert_status, [2] matched, [6:3] record_count, [7] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int KEY_W = 2 * ID_WIDTH + KIND_W;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CFG_DATA_W-1:0] instr_wc_r, data_wc_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  accept, any_dup, any_hit, full;
  logic [OP_W-1:0]       op;
  logic [KEY_W-1:0]      new_key;
  logic [STATUS_W-1:0]   status;
  logic                  matched;
  sfrs_ctrl_t            ctrl;

  logic [KEY_W-1:0]      key_arr [DEPTH];
  sfrs_stat_t            stat_arr [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign op        = in_tuser;
  assign new_key   = {ID_WIDTH'(in_tdata[7:0]), ID_WIDTH'(in_tdata[15:8]),
                      in_tdata[16 +: KIND_W]};

  always_comb begin
    any_dup = 1'b0;
    any_hit = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      any_dup = any_dup | stat_arr[i].dup;
      any_hit = any_hit | stat_arr[i].hit;
    end
  end

  assign full     = stat_arr[DEPTH-1].valid;
  assign ctrl.ins = accept && (op == OP_INSERT) && !any_dup && !full;
  assign ctrl.clr = accept && (op == OP_CLEAR);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_W-1:0] p_key;
      logic             p_valid, p_shift;
      if (g == 0) begin : g_head
        assign p_key   = new_key;
        assign p_valid = 1'b1;
        assign p_shift = 1'b0;
      end else begin : g_body
        assign p_key   = key_arr[g-1];
        assign p_valid = stat_arr[g-1].valid;
        assign p_shift = stat_arr[g-1].shift;
      end
      sfrs_cell #(.ID_WIDTH(ID_WIDTH)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_key    (new_key),
        .instr_wc   (ID_WIDTH'(instr_wc_r)),
        .data_wc    (ID_WIDTH'(data_wc_r)),
        .prev_key   (p_key),
        .prev_valid (p_valid),
        .prev_shift (p_shift),
        .key        (key_arr[g]),
        .stat       (stat_arr[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    status    = ST_NONE;
    matched   = 1'b0;
    case (op)
      OP_INSERT: begin
        if (any_dup) begin
          status = ST_DUPLICATE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status    = ST_INSERTED;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_QUERY: begin
        matched = any_hit;
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status = ST_NONE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, REC_CNT_W'(count_nxt), matched, status};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      instr_wc_r  <= '0;
      data_wc_r   <= '0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_INSTR_WC: instr_wc_r <= cfg_data;
          CFG_DATA_WC:  data_wc_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: design/sfrs_checker.sv
`include "sorted_fault_record_set_macros.svh"

module sfrs_checker import sfrs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  `SFRS_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid, "result valid after reset")

  `SFRS_ASSERT_NEXT(a_result_follows, in_tvalid && in_tready, out_tvalid, "word lost")

  `SFRS_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  `SFRS_ASSERT_NOW(a_count_bound, out_tvalid, out_tdata[6:3] <= DEPTH, "record count above depth")

  `SFRS_ASSERT_NOW(a_match_query_only, out_tvalid && out_tdata[2], out_tdata[1:0] == ST_NONE, "match flagged on insert")

endmodule

bind sorted_fault_record_set sfrs_checker #(.DEPTH(DEPTH)) u_sfrs_checker (.*);
